### design/fps_pkg.sv
// shared constants, types and state encoding for the binary indexed tree block
package fps_pkg;

    localparam int unsigned MAX_ELEMENTS = 1024;
    localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);
    // tree positions run 1..MAX_ELEMENTS and the climb may step past it once
    localparam int unsigned POS_W        = IDX_W + 2;
    localparam int unsigned COUNT_W      = 11;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned PADDR_W      = 3;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_ELEMENTS);

    localparam logic CMD_UPDATE   = 1'b0;
    localparam logic CMD_QUERY    = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ELEMENT_COUNT = 1'b0;

    typedef struct packed {
        logic              is_query;
        logic              bad;
        logic [IDX_W-1:0]  index_low;
        logic [IDX_W-1:0]  index_high;
        logic [DATA_W-1:0] amount;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WALK,
        BK_FINISH
    } back_state_t;

endpackage

### design/fps_front.sv
// front end: element count register, apb port, command accept and range check
module fps_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              command,
    input  logic [fps_pkg::IDX_W-1:0]         index_low,
    input  logic [fps_pkg::IDX_W-1:0]         index_high,
    input  logic signed [fps_pkg::DATA_W-1:0] add_value,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fps_pkg::PADDR_W-1:0]       paddr,
    input  logic [fps_pkg::DATA_W-1:0]        pwdata,
    output logic [fps_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              queue_full,
    input  logic                              clearing,
    output logic                              busy,
    output logic                              push,
    output fps_pkg::cmd_t                     push_cmd
);

    logic [fps_pkg::COUNT_W-1:0] count_reg;
    logic [fps_pkg::COUNT_W-1:0] count_next;
    logic [fps_pkg::COUNT_W-1:0] eff_count;
    logic                        cfg_write;
    logic                        low_bad;
    logic                        high_bad;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == fps_pkg::REG_ELEMENT_COUNT);

    always_comb
    begin
        count_next = count_reg;
        if (cfg_write)
        begin
            count_next = pwdata[fps_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= fps_pkg::COUNT_RESET;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign prdata = (paddr[2] == fps_pkg::REG_ELEMENT_COUNT)
                    ? {{(fps_pkg::DATA_W-fps_pkg::COUNT_W){1'b0}}, count_reg}
                    : '0;

    // count clipped to the store size
    assign eff_count = (count_reg > fps_pkg::COUNT_MAX) ? fps_pkg::COUNT_MAX : count_reg;

    assign low_bad  = ({1'b0, index_low}  >= eff_count);
    assign high_bad = ({1'b0, index_high} >= eff_count);

    assign busy = clearing || queue_full;
    assign push = start && !busy;

    always_comb
    begin
        push_cmd.is_query   = (command == fps_pkg::CMD_QUERY);
        push_cmd.bad        = (command == fps_pkg::CMD_QUERY) ? (low_bad || high_bad) : low_bad;
        push_cmd.index_low  = index_low;
        push_cmd.index_high = index_high;
        push_cmd.amount     = add_value;
    end

endmodule

### design/fps_queue.sv
// short command queue between the front end and the tree walker
module fps_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fps_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output fps_pkg::queue_head_t head,
    output logic                 full
);

    fps_pkg::cmd_t                entry_reg [fps_pkg::QUEUE_DEPTH];
    logic [fps_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [fps_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [fps_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [fps_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [fps_pkg::QCNT_W-1:0]   fill_reg;
    logic [fps_pkg::QCNT_W-1:0]   fill_next;
    logic                         do_pop;

    assign full   = (fill_reg == fps_pkg::QCNT_W'(fps_pkg::QUEUE_DEPTH));
    assign do_pop = pop && (fill_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + fps_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + fps_pkg::QPTR_W'(1);
        end
        if (push && !do_pop)
        begin
            fill_next = fill_reg + fps_pkg::QCNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            fill_next = fill_reg - fps_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head.valid = (fill_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

endmodule

### design/fps_back.sv
// back end: tree store, clearing sweep, climb and prefix walks
module fps_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fps_pkg::queue_head_t              head,
    output logic                              pop,
    output logic                              clearing,
    output logic                              done,
    output logic signed [fps_pkg::DATA_W-1:0] range_sum,
    output logic                              status
);

    logic [fps_pkg::DATA_W-1:0] tree_mem [fps_pkg::MAX_ELEMENTS];
    logic [fps_pkg::DATA_W-1:0] rdata_reg;

    fps_pkg::back_state_t       state_reg;
    fps_pkg::back_state_t       state_next;
    fps_pkg::cmd_t              cur_reg;
    fps_pkg::cmd_t              cur_next;
    logic [fps_pkg::IDX_W-1:0]  clr_addr_reg;
    logic [fps_pkg::IDX_W-1:0]  clr_addr_next;
    logic [fps_pkg::POS_W-1:0]  pos_reg;
    logic [fps_pkg::POS_W-1:0]  pos_next;
    logic                       phase_reg;
    logic                       phase_next;
    logic [fps_pkg::DATA_W-1:0] acc_reg;
    logic [fps_pkg::DATA_W-1:0] acc_next;
    logic                       status_reg;
    logic                       status_next;
    logic                       rd_valid_reg;
    logic                       rd_valid_next;
    logic                       rd_neg_reg;
    logic                       rd_neg_next;
    logic [fps_pkg::IDX_W-1:0]  rd_addr_reg;
    logic [fps_pkg::IDX_W-1:0]  rd_addr_next;

    logic                       mem_we;
    logic [fps_pkg::IDX_W-1:0]  mem_waddr;
    logic [fps_pkg::DATA_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [fps_pkg::IDX_W-1:0]  mem_raddr;

    logic [fps_pkg::POS_W-1:0]  low_bit;
    logic [fps_pkg::POS_W-1:0]  pos_m1;
    logic                       walk_more;
    logic                       second_walk;

    assign low_bit     = pos_reg & (~pos_reg + fps_pkg::POS_W'(1));
    assign pos_m1      = pos_reg - fps_pkg::POS_W'(1);
    assign walk_more   = (pos_reg != '0) && (pos_reg <= fps_pkg::POS_W'(fps_pkg::MAX_ELEMENTS));
    assign second_walk = cur_reg.is_query && !phase_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fps_pkg::BK_CLEAR:
            begin
                if (clr_addr_reg == fps_pkg::IDX_W'(fps_pkg::MAX_ELEMENTS - 1))
                begin
                    state_next = fps_pkg::BK_IDLE;
                end
            end
            fps_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = head.cmd.bad ? fps_pkg::BK_FINISH : fps_pkg::BK_WALK;
                end
            end
            fps_pkg::BK_WALK:
            begin
                if (!walk_more && !second_walk)
                begin
                    state_next = fps_pkg::BK_FINISH;
                end
            end
            fps_pkg::BK_FINISH:
            begin
                state_next = fps_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = fps_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cur_next      = cur_reg;
        clr_addr_next = clr_addr_reg;
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        status_next   = status_reg;
        rd_valid_next = 1'b0;
        rd_neg_next   = rd_neg_reg;
        rd_addr_next  = rd_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = rd_addr_reg;
        mem_wdata     = rdata_reg + cur_reg.amount;
        mem_re        = 1'b0;
        mem_raddr     = pos_m1[fps_pkg::IDX_W-1:0];
        pop           = 1'b0;
        done          = 1'b0;
        clearing      = 1'b0;
        case (state_reg)
            fps_pkg::BK_CLEAR:
            begin
                clearing      = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + fps_pkg::IDX_W'(1);
            end
            fps_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    cur_next    = head.cmd;
                    acc_next    = '0;
                    phase_next  = 1'b0;
                    status_next = head.cmd.bad ? fps_pkg::STATUS_RANGE : fps_pkg::STATUS_OK;
                    pos_next    = head.cmd.is_query
                                  ? fps_pkg::POS_W'(head.cmd.index_high) + fps_pkg::POS_W'(1)
                                  : fps_pkg::POS_W'(head.cmd.index_low) + fps_pkg::POS_W'(1);
                end
            end
            fps_pkg::BK_WALK:
            begin
                // retire the word read last cycle
                if (rd_valid_reg)
                begin
                    if (cur_reg.is_query)
                    begin
                        acc_next = rd_neg_reg ? (acc_reg - rdata_reg) : (acc_reg + rdata_reg);
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
                // issue the next read of the chain
                if (walk_more)
                begin
                    mem_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_addr_next  = pos_m1[fps_pkg::IDX_W-1:0];
                    rd_neg_next   = phase_reg;
                    pos_next      = cur_reg.is_query ? (pos_reg - low_bit) : (pos_reg + low_bit);
                end
                else if (second_walk)
                begin
                    phase_next = 1'b1;
                    pos_next   = fps_pkg::POS_W'(cur_reg.index_low);
                end
            end
            fps_pkg::BK_FINISH:
            begin
                done = 1'b1;
                pop  = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign range_sum = acc_reg;
    assign status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fps_pkg::BK_CLEAR;
            clr_addr_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        pos_reg     <= pos_next;
        phase_reg   <= phase_next;
        acc_reg     <= acc_next;
        status_reg  <= status_next;
        rd_neg_reg  <= rd_neg_next;
        rd_addr_reg <= rd_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tree_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= tree_mem[mem_raddr];
        end
    end

endmodule

### design/fenwick_prefix_sum_1d.sv
// top level of the binary indexed tree: point add and range sum over 1024 wrapping words
//
// a command word is taken when start is high and busy is low; its single result word
// appears on range_sum and status for exactly one cycle with done high, and cannot be
// held off. after reset the tree store is swept to zero, one entry a cycle, and busy
// stays high until the sweep ends (apb writes are taken throughout). a two-word command
// queue sits between the front end, which holds the element count and flags out-of-range
// indices, and the tree walker, so a new command can be taken while the previous one is
// still walking. the walker owns a single-port read and single-port write store, one tree
// word a cycle, and the read data comes back through a register; a range sum is two prefix
// walks of up to ten reads each, a point add climbs up to eleven positions, and a command
// with an index beyond the element count goes straight to the finish state with status
// high and range_sum zero. element_count sits at byte address 0 of the apb port.
module fenwick_prefix_sum_1d (
    input  logic                              clk,
    input  logic                              rst_n,
    // command word
    input  logic                              start,
    output logic                              busy,
    input  logic                              command,
    input  logic [fps_pkg::IDX_W-1:0]         index_low,
    input  logic [fps_pkg::IDX_W-1:0]         index_high,
    input  logic signed [fps_pkg::DATA_W-1:0] add_value,
    // result word
    output logic                              done,
    output logic signed [fps_pkg::DATA_W-1:0] range_sum,
    output logic                              status,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fps_pkg::PADDR_W-1:0]       paddr,
    input  logic [fps_pkg::DATA_W-1:0]        pwdata,
    output logic [fps_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    logic                 push;
    fps_pkg::cmd_t        push_cmd;
    logic                 pop;
    logic                 queue_full;
    logic                 clearing;
    fps_pkg::queue_head_t head;

    // count register and range check, pushes classified commands
    fps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .index_low  (index_low),
        .index_high (index_high),
        .add_value  (add_value),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .queue_full (queue_full),
        .clearing   (clearing),
        .busy       (busy),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // decouples acceptance from the tree walk
    fps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (queue_full)
    );

    // tree store and walker, one result word per command
    fps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .done      (done),
        .range_sum (range_sum),
        .status    (status)
    );

endmodule

### test/testbench.sv
// self-checking testbench for the binary indexed tree block: point adds and range sums
`timescale 1ns / 100ps

module testbench;

    import fps_pkg::*;

    // cycles with nothing taken or returned before the run is called hung
    localparam int unsigned STALL_LIMIT = 4000;
    // quiet cycles allowed after the last result word before touching the apb port
    localparam int unsigned SETTLE_CYCLES = 40;
    // percentage of cycles in which the sender holds back
    localparam int unsigned IDLE_PERCENT = 22;

    // byte addresses on the apb port: element_count, and one slot the block does not decode
    localparam logic [PADDR_W-1:0] ADDR_COUNT = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] ADDR_SPARE = PADDR_W'(4);

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [DATA_W-1:0] amount;
    } tree_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic              flag;
    } tree_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     command = CMD_UPDATE;
    logic [IDX_W-1:0]         index_low = '0;
    logic [IDX_W-1:0]         index_high = '0;
    logic signed [DATA_W-1:0] add_value = '0;
    logic                     done;
    logic signed [DATA_W-1:0] range_sum;
    logic                     status;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    fenwick_prefix_sum_1d DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .index_low  (index_low),
        .index_high (index_high),
        .add_value  (add_value),
        .done       (done),
        .range_sum  (range_sum),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // ------------------------------------------------------------------
    // shadow of the block: tree words at positions 1..MAX_ELEMENTS and the
    // element count, both kept in step with every word the block takes
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]  tree_words [1:MAX_ELEMENTS];
    logic [COUNT_W-1:0] count_shadow = COUNT_RESET;

    tree_cmd_t    pending_words [$];
    tree_result_t sums_due [$];
    tree_cmd_t    on_bus;
    tree_result_t predicted;
    tree_result_t arrived_due;

    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned results_seen = 0;
    int unsigned update_words = 0;
    int unsigned query_words = 0;
    int unsigned flagged_words = 0;
    int unsigned count_settings = 0;
    int unsigned fault_count = 0;
    int unsigned idle_cycles = 0;
    bit          no_idle = 1'b0;

    initial
    begin
        for (int p = 1; p <= MAX_ELEMENTS; p++)
        begin
            tree_words[p] = '0;
        end
    end

    // element count after clamping to the size of the store
    function automatic int unsigned live_count();
        return (count_shadow < COUNT_MAX) ? int'(count_shadow) : MAX_ELEMENTS;
    endfunction

    // wrapped sum of elements 0..n-1, walking down by the lowest set bit
    function automatic logic [DATA_W-1:0] prefix_total(input int unsigned n);
        logic [DATA_W-1:0] acc;
        int unsigned       pos;
        acc = '0;
        pos = n;
        while (pos > 0)
        begin
            acc = acc + tree_words[pos];
            pos = pos - (pos & (~pos + 1));
        end
        return acc;
    endfunction

    // applies one command word to the shadow tree and returns the result word it should give
    function automatic tree_result_t fenwick_apply(input tree_cmd_t w);
        tree_result_t r;
        int unsigned  n;
        int unsigned  pos;
        n = live_count();
        r.sum = '0;
        r.flag = STATUS_OK;
        if (w.cmd == CMD_UPDATE)
        begin
            if (w.lo >= n)
            begin
                r.flag = STATUS_RANGE;
            end
            else
            begin
                // the climb always runs to the top of the store, whatever the count
                pos = w.lo + 1;
                while (pos <= MAX_ELEMENTS)
                begin
                    tree_words[pos] = tree_words[pos] + w.amount;
                    pos = pos + (pos & (~pos + 1));
                end
            end
        end
        else if (w.lo >= n || w.hi >= n)
        begin
            r.flag = STATUS_RANGE;
        end
        else
        begin
            // a reversed range just gives the negated sum of the gap
            r.sum = prefix_total(w.hi + 1) - prefix_total(w.lo);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input logic c, input int unsigned lo, input int unsigned hi,
                              input logic [DATA_W-1:0] amt);
        tree_cmd_t w;
        w.cmd = c;
        w.lo = IDX_W'(lo);
        w.hi = IDX_W'(hi);
        w.amount = amt;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // mostly in-range words with random content, some beyond the count, some pure noise
    function automatic tree_cmd_t random_word(input int unsigned n);
        tree_cmd_t   w;
        int unsigned kind;
        int unsigned tmp;
        kind = $urandom_range(99);
        w.cmd = $urandom_range(1) ? CMD_QUERY : CMD_UPDATE;
        w.lo = IDX_W'($urandom);
        w.hi = IDX_W'($urandom);
        if (n != 0 && kind >= 10)
        begin
            w.lo = IDX_W'($urandom_range(n - 1, 0));
            w.hi = IDX_W'($urandom_range(n - 1, 0));
            if (kind < 18 && n < MAX_ELEMENTS)
            begin
                // push one end past the count
                if (w.cmd == CMD_UPDATE || $urandom_range(1))
                begin
                    w.lo = IDX_W'($urandom_range(MAX_ELEMENTS - 1, n));
                end
                else
                begin
                    w.hi = IDX_W'($urandom_range(MAX_ELEMENTS - 1, n));
                end
            end
            else if (kind < 88 && w.lo > w.hi)
            begin
                tmp = w.lo;
                w.lo = w.hi;
                w.hi = IDX_W'(tmp);
            end
        end
        case ($urandom_range(7))
            0:       w.amount = 32'h7fff_ffff;
            1:       w.amount = 32'h8000_0000;
            2:       w.amount = DATA_W'(int'($urandom_range(200)) - 100);
            default: w.amount = $urandom;
        endcase
        return w;
    endfunction

    task automatic fill_random(input int unsigned count);
        for (int i = 0; i < count; i++)
        begin
            pending_words.push_back(random_word(live_count()));
            words_queued++;
        end
    endtask

    // holds the sender until every word is taken and every result word is back
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (words_taken != words_queued || sums_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_count_readback();
        logic [DATA_W-1:0] got;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_COUNT;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== DATA_W'(count_shadow))
        begin
            $error("element_count: expected %0d, got %0d", count_shadow, got);
            fault_count++;
        end
    endtask

    task automatic set_count(input int unsigned value);
        apb_write(ADDR_COUNT, DATA_W'(value));
        count_shadow = COUNT_W'(value);
        count_settings++;
        check_count_readback();
    endtask

    // ------------------------------------------------------------------
    // driver: presents the next pending word, holds it until taken,
    // and idles now and then between words
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predicted = fenwick_apply(on_bus);
                sums_due.push_back(predicted);
                if (on_bus.cmd == CMD_UPDATE)
                begin
                    update_words++;
                end
                else
                begin
                    query_words++;
                end
                if (predicted.flag == STATUS_RANGE)
                begin
                    flagged_words++;
                end
                words_taken++;
            end
            if (!start || !busy)
            begin
                if (pending_words.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    on_bus = pending_words.pop_front();
                    start <= 1'b1;
                    command <= on_bus.cmd;
                    index_low <= on_bus.lo;
                    index_high <= on_bus.hi;
                    add_value <= on_bus.amount;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every result word is checked against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (sums_due.size() == 0)
            begin
                $error("result word with nothing outstanding: range_sum %0d status %0d",
                       range_sum, status);
                fault_count++;
            end
            else
            begin
                arrived_due = sums_due.pop_front();
                if (range_sum !== arrived_due.sum)
                begin
                    $error("range_sum: expected %0d, got %0d",
                           $signed(arrived_due.sum), range_sum);
                    fault_count++;
                end
                if (status !== arrived_due.flag)
                begin
                    $error("status: expected %0d, got %0d", arrived_due.flag, status);
                    fault_count++;
                end
            end
            results_seen++;
        end
    end

    // stall counter, cleared whenever a word goes in or comes out
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("timeout: %0d words taken, %0d results outstanding",
                 words_taken, sums_due.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence: phases at different element counts, drained in between
    // so the count only changes while the block is idle
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // full size: extremes of value and index, whole range, reversed ranges
        set_count(1024);
        queue_word(CMD_QUERY, 0, 1023, 0);
        queue_word(CMD_UPDATE, 0, 0, 32'h7fff_ffff);
        queue_word(CMD_UPDATE, 1023, 1023, 32'h8000_0000);
        queue_word(CMD_UPDATE, 511, 0, 32'hffff_ffff);
        queue_word(CMD_UPDATE, 512, 1023, 32'h0000_0001);
        queue_word(CMD_UPDATE, 0, 1023, 32'h0000_0001);
        queue_word(CMD_QUERY, 0, 0, 32'hffff_ffff);
        queue_word(CMD_QUERY, 0, 1023, 0);
        queue_word(CMD_QUERY, 1023, 1023, 0);
        queue_word(CMD_QUERY, 1023, 0, 0);
        queue_word(CMD_QUERY, 511, 512, 0);
        queue_word(CMD_QUERY, 600, 300, 0);
        queue_word(CMD_QUERY, 1, 1022, 0);
        queue_word(CMD_QUERY, 682, 341, 0);
        fill_random(360);
        drain();

        // a single element: the tree keeps its words from the earlier phase
        set_count(1);
        queue_word(CMD_QUERY, 0, 0, 0);
        queue_word(CMD_UPDATE, 1, 0, 32'h1234_5678);
        queue_word(CMD_QUERY, 0, 1, 0);
        fill_random(40);
        drain();

        // zero count: everything is out of range
        set_count(0);
        queue_word(CMD_UPDATE, 0, 0, 32'h0000_0005);
        queue_word(CMD_QUERY, 0, 0, 0);
        fill_random(25);
        drain();

        // count above the store clamps to full size; sender never idles here
        no_idle = 1'b1;
        set_count(2047);
        fill_random(150);
        drain();
        no_idle = 1'b0;

        set_count(5);
        queue_word(CMD_UPDATE, 5, 0, 32'h0000_0007);
        queue_word(CMD_UPDATE, 1023, 0, 32'h0000_0007);
        queue_word(CMD_QUERY, 0, 5, 0);
        queue_word(CMD_QUERY, 5, 0, 0);
        queue_word(CMD_QUERY, 4, 4, 0);
        fill_random(60);
        drain();

        set_count(300);
        fill_random(150);
        drain();

        set_count(17);
        fill_random(70);
        drain();

        // a write to an undecoded address must leave the count alone
        apb_write(ADDR_SPARE, DATA_W'(3));
        check_count_readback();
        fill_random(60);
        drain();

        set_count(1024);
        fill_random(40);
        drain();

        if (sums_due.size() != 0)
        begin
            $error("%0d result words never arrived", sums_due.size());
            fault_count++;
        end

        $display("covered %0d point adds and %0d range sums, %0d of them beyond the count",
                 update_words, query_words, flagged_words);
        $display("over %0d element count settings; %0d result words checked",
                 count_settings, results_seen);
        if (fault_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### files.f
design/fps_pkg.sv
design/fps_front.sv
design/fps_queue.sv
design/fps_back.sv
design/fenwick_prefix_sum_1d.sv
test/testbench.sv
